// File: hw/rtl/plh_pkg.sv
// Package for the packet length histogram block: table geometry, entry layout,
// configuration codes, controller/datapath command and status structs, and the hash.
// Depends on nothing; every other file of the block but plh_ram imports it.
package plh_pkg;

  // Table geometry. The depth is a power of two from 16 to 65536.
  localparam int TABLE_DEPTH = 8192;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 32;
  localparam int LEN_W   = 8;

  // One table entry holds the used flag, the key and the count.
  localparam int ENTRY_W = 1 + KEY_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [31:0]        HASH_MULT = 32'd2654435761;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-3:0] REG_MIN_FRAME_LEN = '0;
  localparam logic [LEN_W-1:0]  MIN_FRAME_LEN_RST = 8'd14;

  typedef struct packed {
    logic                 used;
    logic [KEY_W-1:0]     key;
    logic [COUNT_W-1:0]   count;
  } plh_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write an empty entry at the sweep address and advance
    logic load_key;  // capture an input beat and its home slot
    logic rd_en;     // read the entry at the probe address
    logic step;      // move the probe to the next slot
    logic commit;    // write back the entry and load the result register
  } plh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // sweep is at the last entry
    logic used;        // entry just read is occupied
    logic hit;         // entry just read holds the probed key
    logic last_probe;  // every slot has now been visited
    logic out_busy;    // result register holds a beat that is not taken now
  } plh_sts_t;

  // Home slot of a key: two xor-shift rounds, then a multiply whose low
  // index bits depend only on the low index bits of both operands.
  function automatic logic [IDX_W-1:0] plh_hash(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] k1;
    logic [KEY_W-1:0] k2;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] p;
    k1 = k ^ {12'b0, k[15:12]};
    k2 = k1 ^ (k1 >> 7) ^ (k1 >> 4);
    a  = k2[IDX_W-1:0];
    b  = HASH_MULT[IDX_W-1:0];
    p  = a * b;
    return p;
  endfunction

endpackage

// File: hw/rtl/plh_in_if.sv
// Input channel of the packet length histogram block: valid, ready and one length.
// Depends on plh_pkg.
interface plh_in_if import plh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] pkt_len;

  modport source (output valid, output pkt_len, input ready);
  modport sink   (input valid, input pkt_len, output ready);
endinterface

// File: hw/rtl/plh_out_if.sv
// Result channel of the packet length histogram block: valid, ready, action,
// count and stored flag. Depends on plh_pkg.
interface plh_out_if import plh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COUNT_W-1:0] count;
  logic               stored;

  modport source (output valid, output action, output count, output stored, input ready);
  modport sink   (input valid, input action, input count, input stored, output ready);
endinterface

// File: hw/rtl/packet_length_histogram_hash.sv
// Packet length histogram: each input beat carries one packet length, which is
// counted in an open-addressing hash table with linear probing, and each beat
// gives one result beat with the running count, a stored flag and a transmit
// decision against min_frame_len. After reset the block sweeps the table RAM
// clean, one entry a cycle, and takes no input beat until that sweep is done;
// configuration writes are taken throughout. An accepted item goes through
// ST_READ and ST_CHECK once per slot probed: each probe is one read of the
// single table RAM followed by one compare, and the commit in ST_CHECK loads
// the result register. A new item is accepted only in ST_IDLE, so not before
// the last one has committed. A full table costs TABLE_DEPTH probes. The result
// register lets the next item enter while a result waits to be taken.
// Depends on plh_pkg, plh_in_if, plh_out_if, plh_cfg, plh_ctrl and plh_dp.
module packet_length_histogram_hash import plh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  plh_in_if.sink            in_i,
  plh_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  plh_cmd_t         cmd;
  plh_sts_t         sts;
  logic [LEN_W-1:0] min_frame_len;
  logic             in_ready;

  // Configuration register.
  plh_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .min_frame_len_o (min_frame_len)
  );

  // Controller.
  plh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Datapath.
  plh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pkt_len_i       (in_i.pkt_len),
    .min_frame_len_i (min_frame_len),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_action_o    (out_o.action),
    .out_count_o     (out_o.count),
    .out_stored_o    (out_o.stored)
  );

endmodule

// File: hw/rtl/plh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module plh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/plh_cfg.sv
// APB-style configuration port of the packet length histogram block.
// Holds the minimum frame length register. Depends on plh_pkg.
module plh_cfg import plh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  min_frame_len_o
);

  logic [LEN_W-1:0] min_len_q, min_len_d;
  logic             wr_en;
  logic             sel_min;

  assign pready  = 1'b1;
  assign sel_min = (paddr[CFG_AW-1:2] == REG_MIN_FRAME_LEN);
  assign wr_en   = psel && penable && pwrite;

  // Register write; writes to unknown addresses are ignored.
  always_comb begin
    min_len_d = min_len_q;
    if (wr_en && sel_min) begin
      min_len_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_FRAME_LEN_RST;
    end else begin
      min_len_q <= min_len_d;
    end
  end

  // Read back.
  assign prdata = sel_min ? {{(32 - LEN_W){1'b0}}, min_len_q} : 32'd0;

  assign min_frame_len_o = min_len_q;

endmodule

// File: hw/rtl/plh_ctrl.sv
// Controller of the packet length histogram block: clearing sweep after reset,
// input acceptance and the probe sequence. Depends on plh_pkg.
module plh_ctrl import plh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  plh_sts_t sts_i,
  output plh_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CHECK = 4'b1000
  } plh_state_e;

  plh_state_e state_q, state_d;
  logic       probe_end;

  // A probe ends at a free slot, at the matching slot, or after the last slot.
  assign probe_end = !sts_i.used || sts_i.hit || sts_i.last_probe;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_key = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        if (probe_end) begin
          // Wait here while the result register still holds a beat.
          if (!sts_i.out_busy) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/plh_dp.sv
// Datapath of the packet length histogram block: key and probe registers, hash,
// table RAM, count update and the result register. Depends on plh_pkg and plh_ram.
module plh_dp import plh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  plh_cmd_t           cmd_i,
  output plh_sts_t           sts_o,
  input  logic [KEY_W-1:0]   pkt_len_i,
  input  logic [LEN_W-1:0]   min_frame_len_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_action_o,
  output logic [COUNT_W-1:0] out_count_o,
  output logic               out_stored_o
);

  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [IDX_W-1:0]   probe_q, probe_d;
  logic               out_valid_q, out_valid_d;
  logic               action_q;
  logic [COUNT_W-1:0] count_q;
  logic               stored_q;

  logic [ENTRY_W-1:0] rdata;
  plh_entry_t         rd_entry;
  plh_entry_t         wr_entry;
  logic               hit;
  logic               full;
  logic [COUNT_W-1:0] new_count;
  logic               ram_we;

  // Table RAM.
  plh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign rd_entry = plh_entry_t'(rdata);
  assign hit      = rd_entry.used && (rd_entry.key == key_q);
  assign full     = rd_entry.used && !hit && (probe_q == IDX_W'(TABLE_DEPTH - 1));

  // New count: one for a claimed slot, a saturating increment for a match.
  always_comb begin
    if (!rd_entry.used) begin
      new_count = COUNT_W'(1);
    end else if (rd_entry.count == COUNT_MAX) begin
      new_count = COUNT_MAX;
    end else begin
      new_count = rd_entry.count + COUNT_W'(1);
    end
  end

  // Write back: empty entries during the sweep, else the updated entry on a commit unless the table is full.
  assign ram_we = cmd_i.clr_step || (cmd_i.commit && !full);
  always_comb begin
    if (cmd_i.clr_step) begin
      wr_entry = '0;
    end else begin
      wr_entry.used  = 1'b1;
      wr_entry.key   = key_q;
      wr_entry.count = new_count;
    end
  end

  // Probe address and probe counter.
  always_comb begin
    addr_d  = addr_q;
    probe_d = probe_q;
    if (cmd_i.clr_step) begin
      addr_d = addr_q + IDX_W'(1);
    end else if (cmd_i.load_key) begin
      addr_d  = plh_hash(pkt_len_i);
      probe_d = '0;
    end else if (cmd_i.step) begin
      addr_d  = addr_q + IDX_W'(1);
      probe_d = probe_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      probe_q <= '0;
    end else begin
      addr_q  <= addr_d;
      probe_q <= probe_d;
    end
  end

  // Key register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= pkt_len_i;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      action_q <= (key_q >= {{(KEY_W - LEN_W){1'b0}}, min_frame_len_i});
      count_q  <= full ? '0 : new_count;
      stored_q <= !full;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_action_o = action_q;
  assign out_count_o  = count_q;
  assign out_stored_o = stored_q;

  // Status.
  assign sts_o.clr_last   = (addr_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.used       = rd_entry.used;
  assign sts_o.hit        = hit;
  assign sts_o.last_probe = (probe_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

// File: bench/tb_packet_length_histogram_hash.sv
`timescale 1ns / 1ps
// Testbench for packet_length_histogram_hash: drives packet length beats and
// min_frame_len writes, predicts every result beat and checks it field by field.
// Depends on plh_pkg, plh_in_if, plh_out_if and the block itself.
module tb_packet_length_histogram_hash;
  import plh_pkg::*;

  localparam int KEY_SPACE     = 1 << KEY_W;
  localparam int KEYS_PER_SLOT = KEY_SPACE / TABLE_DEPTH;
  localparam logic [CFG_AW-3:0] REG_UNUSED = '1;
  localparam int N_HOT_LENS  = 48;
  localparam int N_HOT_SLOTS = 16;
  localparam int SEG_ITEMS   = 250;

  typedef struct packed {
    logic               action;
    logic [COUNT_W-1:0] count;
    logic               stored;
  } len_result_t;

  typedef struct {
    logic [KEY_W-1:0] len;
    bit               typed;
    len_result_t      res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  plh_in_if  in_ch ();
  plh_out_if out_ch ();

  packet_length_histogram_hash DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Own copy of the length table and of min_frame_len.
  bit                 hist_used [TABLE_DEPTH];
  logic [KEY_W-1:0]   hist_key  [TABLE_DEPTH];
  logic [COUNT_W-1:0] hist_cnt  [TABLE_DEPTH];
  logic [LEN_W-1:0]   min_len_q;
  bit                 len_in_table [KEY_SPACE];

  // Up to KEYS_PER_SLOT lengths for each home slot, to build probe chains on purpose.
  logic [KEY_W-1:0] slot_keys [TABLE_DEPTH][KEYS_PER_SLOT];
  int               slot_fill [TABLE_DEPTH];

  logic [KEY_W-1:0] hot_lens  [N_HOT_LENS];
  int               hot_slots [N_HOT_SLOTS];
  dir_row_t         dir_rows [$];
  len_result_t      pending_results [$];
  int               mismatch_cnt;
  int               src_items;
  bit               src_calm;
  bit               snk_calm;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Home slot: two xor-shift rounds, multiply, keep the index bits.
  function automatic logic [IDX_W-1:0] home_slot_of(logic [KEY_W-1:0] len);
    logic [31:0] k;
    k = 32'(len);
    k = k ^ (k >> 20) ^ (k >> 12);
    k = k ^ (k >> 7) ^ (k >> 4);
    k = k * HASH_MULT;
    return k[IDX_W-1:0];
  endfunction

  // Counts one packet length in the table and returns the result beat it gives.
  function automatic len_result_t count_length(logic [KEY_W-1:0] len);
    len_result_t r;
    int          p;
    r.action = (len < min_len_q) ? 1'b0 : 1'b1;
    r.count  = '0;
    r.stored = 1'b0;
    p = int'(home_slot_of(len));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!hist_used[p]) begin
        hist_used[p] = 1'b1;
        hist_key[p]  = len;
        hist_cnt[p]  = 1;
        r.count  = 1;
        r.stored = 1'b1;
        break;
      end
      if (hist_key[p] == len) begin
        if (hist_cnt[p] != COUNT_MAX) hist_cnt[p] = hist_cnt[p] + 1;
        r.count  = hist_cnt[p];
        r.stored = 1'b1;
        break;
      end
      p = (p + 1) % TABLE_DEPTH;
    end
    if (r.stored) len_in_table[len] = 1'b1;
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Random length: repeated sizes, lengths around the threshold, colliding keys.
  function automatic logic [KEY_W-1:0] pick_len();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 35) return hot_lens[$urandom_range(N_HOT_LENS-1)];
    if (r < 50) begin
      v = int'(min_len_q) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      return KEY_W'(v);
    end
    if (r < 70)
      return slot_keys[hot_slots[$urandom_range(N_HOT_SLOTS-1)]][$urandom_range(KEYS_PER_SLOT-1)];
    if (r < 85) return KEY_W'($urandom_range(1600));
    return KEY_W'($urandom());
  endfunction

  function automatic void add_row(logic [KEY_W-1:0] len, bit typed, logic act,
                                  logic [COUNT_W-1:0] cnt, logic st);
    dir_row_t row;
    row.len   = len;
    row.typed = typed;
    row.res   = {act, cnt, st};
    dir_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // Sends one length beat, called and returning at a falling edge. The
  // expectation is recorded at the edge where the beat is taken.
  task automatic send_len(input logic [KEY_W-1:0] len, input bit typed,
                          input len_result_t typed_res);
    int          g;
    len_result_t pred;
    src_items++;
    if (src_items % 50 == 0) src_calm = ($urandom_range(3) == 0);
    g = gap_len(src_calm);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pkt_len <= len;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = count_length(len);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // Lets every result beat come back before the block is touched otherwise.
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready, then idle with psel low.
  task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_min_len();
    logic [31:0] rd;
    apb_access(1'b0, {REG_MIN_FRAME_LEN, 2'b00}, '0, rd);
    if (rd[LEN_W-1:0] !== min_len_q)
      note_mismatch($sformatf("min_frame_len read: expected %0d, got %0d",
                              min_len_q, rd[LEN_W-1:0]));
  endtask

  task automatic set_min_len(input logic [LEN_W-1:0] v);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, {REG_MIN_FRAME_LEN, 2'b00}, 32'(v), rd);
    min_len_q = v;
    check_min_len();
  endtask

  task automatic check_result();
    len_result_t want;
    if (pending_results.size() == 0) begin
      note_mismatch($sformatf("result beat with nothing pending: action %0d count %0d stored %0d",
                              out_ch.action, out_ch.count, out_ch.stored));
      return;
    end
    want = pending_results.pop_front();
    if (out_ch.action !== want.action)
      note_mismatch($sformatf("action: expected %0d, got %0d", want.action, out_ch.action));
    if (out_ch.count !== want.count)
      note_mismatch($sformatf("count: expected %0d, got %0d", want.count, out_ch.count));
    if (out_ch.stored !== want.stored)
      note_mismatch($sformatf("stored: expected %0d, got %0d", want.stored, out_ch.stored));
  endtask

  // Result side: ready changes at the falling edge, beats are checked at the rising edge.
  initial begin
    int stall;
    int beats;
    stall        = 0;
    beats        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        beats++;
        if (beats % 50 == 0) snk_calm = ($urandom_range(3) == 0);
        stall = gap_len(snk_calm);
      end else if (!snk_calm && out_ch.ready && $urandom_range(99) < 4) begin
        stall = $urandom_range(6, 1);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0]      rd;
    logic [KEY_W-1:0] len;
    logic [LEN_W-1:0] seg_min;
    int               s;
    int               hi;
    int               tries;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.pkt_len = '0;
    mismatch_cnt  = 0;
    src_items     = 0;
    src_calm      = 1'b0;
    snk_calm      = 1'b0;
    min_len_q     = MIN_FRAME_LEN_RST;

    // Group all lengths by home slot.
    for (int k = 0; k < KEY_SPACE; k++) begin
      s = int'(home_slot_of(KEY_W'(k)));
      if (slot_fill[s] < KEYS_PER_SLOT) begin
        slot_keys[s][slot_fill[s]] = KEY_W'(k);
        slot_fill[s]++;
      end
    end

    // Common frame sizes plus random ones; the last slot makes chains wrap to slot 0.
    hot_lens[0] = 16'd64;   hot_lens[1] = 16'd128;  hot_lens[2] = 16'd256;
    hot_lens[3] = 16'd512;  hot_lens[4] = 16'd1024; hot_lens[5] = 16'd1500;
    hot_lens[6] = 16'd1518; hot_lens[7] = 16'd9000; hot_lens[8] = 16'd60;
    for (int i = 9; i < N_HOT_LENS; i++) hot_lens[i] = KEY_W'($urandom_range(2000));
    hot_slots[0] = TABLE_DEPTH - 1;
    for (int i = 1; i < N_HOT_SLOTS; i++) hot_slots[i] = $urandom_range(TABLE_DEPTH - 1);

    // Directed rows at the reset threshold of 14.
    add_row(16'd0,      1'b1, 1'b0, 1, 1'b1);
    add_row(16'hFFFF,   1'b1, 1'b1, 1, 1'b1);
    add_row(16'd13,     1'b1, 1'b0, 1, 1'b1);
    add_row(16'd14,     1'b1, 1'b1, 1, 1'b1);
    add_row(16'd15,     1'b1, 1'b1, 1, 1'b1);
    add_row(16'd14,     1'b1, 1'b1, 2, 1'b1);
    add_row(16'd0,      1'b1, 1'b0, 2, 1'b1);
    add_row(16'hFFFF,   1'b1, 1'b1, 2, 1'b1);
    add_row(16'd13,     1'b1, 1'b0, 2, 1'b1);
    add_row(16'd255,    1'b1, 1'b1, 1, 1'b1);
    add_row(16'd256,    1'b1, 1'b1, 1, 1'b1);
    add_row(16'h5555,   1'b1, 1'b1, 1, 1'b1);
    add_row(16'hAAAA,   1'b1, 1'b1, 1, 1'b1);
    add_row(16'd64,     1'b1, 1'b1, 1, 1'b1);
    add_row(16'd1518,   1'b1, 1'b1, 1, 1'b1);
    // The lengths kept for the last slot: the probe runs past the end and wraps.
    for (int j = 0; j < KEYS_PER_SLOT; j++)
      add_row(slot_keys[TABLE_DEPTH-1][j], 1'b0, 1'b0, 0, 1'b0);
    add_row(slot_keys[TABLE_DEPTH-1][0], 1'b0, 1'b0, 0, 1'b0);
    add_row(slot_keys[TABLE_DEPTH-1][KEYS_PER_SLOT-1], 1'b0, 1'b0, 0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_min_len();

    foreach (dir_rows[i]) send_len(dir_rows[i].len, dir_rows[i].typed, dir_rows[i].res);

    // A write to an unused index must leave min_frame_len alone.
    set_min_len(8'd0);
    apb_access(1'b1, {REG_UNUSED, 2'b00}, $urandom(), rd);
    check_min_len();

    // Random segments, each at its own threshold.
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       seg_min = 8'd0;
        1:       seg_min = 8'd255;
        2:       seg_min = 8'd1;
        3:       seg_min = 8'd64;
        4:       seg_min = LEN_W'($urandom_range(255));
        default: seg_min = MIN_FRAME_LEN_RST;
      endcase
      set_min_len(seg_min);
      for (int i = 0; i < SEG_ITEMS; i++) send_len(pick_len(), 1'b0, '0);
    end

    // Fill every free slot with a length that lands there on its first probe.
    set_min_len(LEN_W'($urandom_range(255)));
    for (int p = 0; p < TABLE_DEPTH; p++)
      if (!hist_used[p]) send_len(slot_keys[p][$urandom_range(KEYS_PER_SLOT-1)], 1'b0, '0);

    // Full table: new lengths probe every slot and are not stored, known ones still count.
    set_min_len(8'd255);
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) begin
        hi    = (i < 8) ? 254 : KEY_SPACE - 1;
        tries = 0;
        do begin
          len = KEY_W'($urandom_range(hi));
          tries++;
          if (tries > 1000) hi = KEY_SPACE - 1;
        end while (len_in_table[len]);
      end else begin
        len = hist_key[$urandom_range(TABLE_DEPTH - 1)];
      end
      send_len(len, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
